/* rtl/drs_pkg.sv */
//------------------------------------------------------------------------------
// drs_pkg
// Shared types and constants of the disk request scheduler.
//------------------------------------------------------------------------------
package drs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TRACK_BITS_DEF  = 16;
    localparam int FIELD_TRACK_W   = 16;
    localparam int TIME_W          = 32;
    localparam int POLICY_W        = 3;
    localparam int COUNT_OUT_W     = 6;

    localparam logic [POLICY_W-1:0] POL_FIFO  = 3'd0;
    localparam logic [POLICY_W-1:0] POL_SSTF  = 3'd1;
    localparam logic [POLICY_W-1:0] POL_LOOK  = 3'd2;
    localparam logic [POLICY_W-1:0] POL_CLOOK = 3'd3;
    localparam logic [POLICY_W-1:0] POL_FLOOK = 3'd4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    localparam logic [1:0] PHASE_NONE = 2'd0;
    localparam logic [1:0] PHASE_ONE  = 2'd1;
    localparam logic [1:0] PHASE_TWO  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_SHIFT,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the input beat
        logic prep;       // apply insert or queue swap
        logic scan_start; // restart scan index
        logic scan_step;  // examine one entry
        logic flip;       // reverse look direction
        logic pick;       // latch chosen index into the shift index
        logic shift_step; // compact one entry
        logic finish;     // decrement count, build result
        logic empty_sel;  // select with nothing to serve
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_select;
        logic nothing;    // select finds no entry after prep
        logic scan_last;
        logic found;
        logic need_scan;  // policy needs a scan
        logic look_mode;
        logic shift_last;
    } t_stat;

    typedef struct packed {
        logic                     cmd;
        logic [FIELD_TRACK_W-1:0] new_track;
        logic [FIELD_TRACK_W-1:0] current_head;
        logic [TIME_W-1:0]        now_time;
    } t_req;

    typedef struct packed {
        logic                     granted;
        logic [FIELD_TRACK_W-1:0] served_track;
        logic [TIME_W-1:0]        start_time;
        logic [TIME_W-1:0]        finish_time;
        logic [FIELD_TRACK_W-1:0] seek_distance;
        logic                     insert_dropped;
        logic [COUNT_OUT_W-1:0]   pending_count;
    } t_rsp;

endpackage

/* rtl/drs_if.sv */
//------------------------------------------------------------------------------
// drs_if
// Valid/ready channel carrying one payload beat.
//------------------------------------------------------------------------------
interface drs_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/drs_datapath.sv */
//------------------------------------------------------------------------------
// drs_datapath
// Queue storage, scan comparator, compaction and result formation.
//------------------------------------------------------------------------------
module drs_datapath #(
    parameter int QUEUE_DEPTH = drs_pkg::QUEUE_DEPTH_DEF,
    parameter int TRACK_BITS  = drs_pkg::TRACK_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [drs_pkg::POLICY_W-1:0]  i_policy,
    input  drs_pkg::t_req                 i_req,
    input  drs_pkg::t_cmd                 i_cmd,
    output drs_pkg::t_stat                o_stat,
    output drs_pkg::t_rsp                 o_rsp
);
    import drs_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TB = TRACK_BITS;

    // two banks; r_sel names the bank serving as the active queue
    logic [TB-1:0] r_mem0 [QUEUE_DEPTH];
    logic [TB-1:0] r_mem1 [QUEUE_DEPTH];
    logic [CW-1:0] r_cnt [2];
    logic          r_sel;
    logic          r_up;
    logic [1:0]    r_phase;

    logic [TB-1:0] r_track, r_head;
    logic [TIME_W-1:0] r_now;
    logic          r_cmd;
    logic [POLICY_W-1:0] r_pol;

    logic [CW-1:0] r_idx;     // scan / shift index
    logic          r_found;
    logic [IW-1:0] r_best;
    logic [TB-1:0] r_bestd;
    logic [IW-1:0] r_low;
    logic [TB-1:0] r_lowt;
    logic [TB-1:0] r_rd;      // registered read of active entry at r_idx
    logic [TB-1:0] r_rd1;     // registered read of entry r_idx+1
    logic [TB-1:0] srv;

    logic act, oth;
    assign act = r_sel;
    assign oth = ~r_sel;

    logic [CW-1:0] a_cnt;
    assign a_cnt = r_cnt[act];

    logic flook;
    assign flook = (r_pol == POL_FLOOK);

    // read port: the entry at the index and the one after it, both registered
    logic [IW-1:0] rd_addr, rd_addr1;
    assign rd_addr  = r_idx[IW-1:0];
    assign rd_addr1 = IW'(r_idx + CW'(1));

    // scan compare on the entry read last cycle
    logic [TB-1:0] d;
    logic          ok;
    logic          better;
    logic [CW-1:0] scan_i; // entry being examined is r_idx-1
    assign scan_i = r_idx - CW'(1);
    assign d = (r_rd >= r_head) ? (r_rd - r_head) : (r_head - r_rd);
    always_comb begin
        unique case (r_pol)
            POL_SSTF:            ok = 1'b1;
            POL_CLOOK:           ok = (r_rd >= r_head);
            POL_LOOK, POL_FLOOK: ok = r_up ? (r_rd >= r_head) : (r_rd <= r_head);
            default:             ok = 1'b0;
        endcase
        better = ok && (!r_found || d < r_bestd);
    end

    logic [TB-1:0] seek;
    logic [TIME_W:0] fsum;
    assign seek = (srv >= r_head) ? (srv - r_head) : (r_head - srv);
    assign fsum = {1'b0, r_now} + (TIME_W+1)'(seek);

    // queue memories
    logic wr_en, wr_bank;
    logic [IW-1:0] wr_addr;
    logic [TB-1:0] wr_data;
    always_comb begin
        wr_en = 1'b0; wr_bank = act; wr_addr = rd_addr; wr_data = r_rd1;
        if (i_cmd.prep && r_cmd == CMD_INSERT) begin
            wr_bank = (flook && r_phase != PHASE_NONE) ? oth : act;
            wr_addr = r_cnt[wr_bank][IW-1:0];
            wr_data = r_track;
            wr_en   = (r_cnt[wr_bank] < CW'(QUEUE_DEPTH));
        end else if (i_cmd.shift_step) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && wr_bank) r_mem1[wr_addr] <= wr_data;
        if (wr_en && !wr_bank) r_mem0[wr_addr] <= wr_data;
        r_rd  <= act ? r_mem1[rd_addr]  : r_mem0[rd_addr];
        r_rd1 <= act ? r_mem1[rd_addr1] : r_mem0[rd_addr1];
    end

    // control state of the queues
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt[0] <= '0; r_cnt[1] <= '0;
            r_sel    <= 1'b0;
            r_up     <= 1'b1;
            r_phase  <= PHASE_NONE;
        end else begin
            if (i_cmd.prep) begin
                if (r_cmd == CMD_INSERT) begin
                    if (flook && r_phase == PHASE_NONE) r_phase <= PHASE_ONE;
                    if (wr_en) r_cnt[wr_bank] <= r_cnt[wr_bank] + CW'(1);
                end else if (flook && a_cnt == '0 && r_cnt[oth] != '0) begin
                    r_sel   <= oth;
                    r_phase <= (r_phase == PHASE_TWO) ? PHASE_ONE : PHASE_TWO;
                end
            end
            if (i_cmd.flip)   r_up <= ~r_up;
            if (i_cmd.finish) r_cnt[act] <= a_cnt - CW'(1);
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_req.cmd;
            r_track <= TB'(i_req.new_track);
            r_head  <= TB'(i_req.current_head);
            r_now   <= i_req.now_time;
            r_pol   <= i_policy;
        end
        if (i_cmd.scan_start) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_best  <= '0;
            r_bestd <= '0;
            r_low   <= '0;
            r_lowt  <= '1;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + CW'(1);
            if (r_idx != '0) begin
                if (better) begin
                    r_found <= 1'b1;
                    r_best  <= scan_i[IW-1:0];
                    r_bestd <= d;
                end
                if (scan_i == '0 || r_rd < r_lowt) begin
                    r_low  <= scan_i[IW-1:0];
                    r_lowt <= r_rd;
                end
            end
        end else if (i_cmd.pick) begin
            // chosen index goes to the shift index; its data then passes the registered read
            if (r_pol == POL_SSTF || r_pol == POL_LOOK || r_pol == POL_FLOOK
                || (r_pol == POL_CLOOK && r_found))
                r_idx <= CW'(r_best);
            else if (r_pol == POL_CLOOK)
                r_idx <= CW'(r_low);
            else
                r_idx <= '0;
        end else if (i_cmd.shift_step) begin
            r_idx <= r_idx + CW'(1);
        end
    end

    // the served track reaches the read register after pick: first the index is
    // loaded, then the registered read is made
    logic r_pick_d1, r_pick_d2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick_d1 <= 1'b0;
            r_pick_d2 <= 1'b0;
        end else begin
            r_pick_d1 <= i_cmd.pick;
            r_pick_d2 <= r_pick_d1;
        end
    end
    logic [TB-1:0] r_srv_q;
    always_ff @(posedge i_clk) begin
        if (r_pick_d2) r_srv_q <= r_rd;
    end
    assign srv = r_pick_d2 ? r_rd : r_srv_q;

    // status to controller
    always_comb begin
        o_stat.is_select  = (r_cmd == CMD_SELECT);
        o_stat.nothing    = (a_cnt == '0);
        o_stat.scan_last  = (r_idx == a_cnt);
        o_stat.found      = r_found || (r_idx != '0 && better);
        o_stat.need_scan  = (r_pol == POL_SSTF) || (r_pol == POL_LOOK)
                            || (r_pol == POL_CLOOK) || (r_pol == POL_FLOOK);
        o_stat.look_mode  = (r_pol == POL_LOOK) || (r_pol == POL_FLOOK);
        o_stat.shift_last = (r_idx + CW'(1) >= a_cnt);
    end

    // result
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish || i_cmd.empty_sel || (i_cmd.prep && r_cmd == CMD_INSERT)) begin
            o_rsp.granted        <= i_cmd.finish;
            o_rsp.served_track   <= i_cmd.finish ? FIELD_TRACK_W'(srv) : '0;
            o_rsp.start_time     <= i_cmd.finish ? r_now : '0;
            o_rsp.finish_time    <= !i_cmd.finish ? '0 :
                                    fsum[TIME_W] ? '1 : fsum[TIME_W-1:0];
            o_rsp.seek_distance  <= i_cmd.finish ? FIELD_TRACK_W'(seek) : '0;
            o_rsp.insert_dropped <= i_cmd.prep && !wr_en;
            o_rsp.pending_count  <= COUNT_OUT_W'(r_cnt[0]) + COUNT_OUT_W'(r_cnt[1])
                                    + (wr_en && i_cmd.prep ? COUNT_OUT_W'(1) : '0)
                                    - (i_cmd.finish ? COUNT_OUT_W'(1) : '0);
        end
    end

endmodule

/* rtl/drs_ctrl.sv */
//------------------------------------------------------------------------------
// drs_ctrl
// Sequencer for insert, scan, pick and compaction of one request.
//------------------------------------------------------------------------------
module drs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  drs_pkg::t_stat i_stat,
    output drs_pkg::t_cmd  o_cmd
);
    import drs_pkg::*;

    t_state r_state, n_state;
    logic   r_prep, n_prep;   // first cycle after load applies prep
    logic   r_flipped, n_flipped;
    logic   r_shift_go, n_shift_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_prep     <= 1'b0;
            r_flipped  <= 1'b0;
            r_shift_go <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_prep     <= n_prep;
            r_flipped  <= n_flipped;
            r_shift_go <= n_shift_go;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_prep     = 1'b0;
        n_flipped  = r_flipped;
        n_shift_go = 1'b0;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_prep     = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_prep) begin
                    // apply insert or queue swap, then start scanning
                    o_cmd.prep       = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_flipped        = 1'b0;
                    if (!i_stat.is_select) n_state = S_DONE;
                end else if (i_stat.nothing) begin
                    o_cmd.empty_sel = 1'b1;
                    n_state = S_DONE;
                end else if (!i_stat.need_scan || i_stat.scan_last) begin
                    if (i_stat.need_scan) o_cmd.scan_step = 1'b1;
                    if (i_stat.look_mode && !i_stat.found && !r_flipped) begin
                        o_cmd.flip       = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_step  = 1'b0;
                        n_flipped        = 1'b1;
                    end else begin
                        if (i_stat.look_mode && !i_stat.found) o_cmd.flip = 1'b1;
                        n_state = S_PICK;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_SHIFT;
            end
            S_SHIFT: begin
                // close gaps one entry per step, with a wait state between steps for the registered read of r_idx+1
                if (!r_shift_go) begin
                    n_shift_go = 1'b1;
                end else if (i_stat.shift_last) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_shift_go       = 1'b0;
                    o_cmd.shift_step = 1'b1;
                end
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/disk_request_scheduler_unit.sv */
//------------------------------------------------------------------------------
// disk_request_scheduler_unit
// Two-queue disk request scheduler with FIFO, SSTF, LOOK, C-LOOK, F-LOOK.
//------------------------------------------------------------------------------
// Usage:
//   in_ch carries one request beat: cmd, new_track, current_head, now_time.
//   out_ch returns exactly one result beat for each request beat.
//   i_cfg_we / i_cfg_wdata write the policy register; write only while idle.
// Operation:
//   An insert is applied in a prep step and its result then goes to out_ch. A
//   select takes a prep step, then scans the active queue one entry a cycle
//   through the registered memory read, once more after a LOOK reversal, then
//   a pick step, then compacts the queue one moved entry per step with a wait
//   state between steps. One request is in flight at a time; in_ch is ready
//   only idle.
// Reset:
//   Synchronous active-low i_rst_n empties both queues, sets direction up,
//   clears the F-LOOK phase and sets policy to FIFO. Queue memories are not
//   cleared; only entries below the counts are read.
// Stall:
//   The result holds on out_ch until taken; no new beat is accepted meanwhile.
//------------------------------------------------------------------------------
module disk_request_scheduler_unit #(
    parameter int QUEUE_DEPTH = drs_pkg::QUEUE_DEPTH_DEF,
    parameter int TRACK_BITS  = drs_pkg::TRACK_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [drs_pkg::POLICY_W-1:0] i_cfg_wdata,
    drs_if.sink                          in_ch,
    drs_if.source                        out_ch
);
    import drs_pkg::*;

    logic [POLICY_W-1:0] r_policy;
    t_cmd  cmd;
    t_stat stat;

    // hold the policy register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_policy <= POL_FIFO;
        else if (i_cfg_we) r_policy <= i_cfg_wdata;
    end

    drs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    drs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .TRACK_BITS(TRACK_BITS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_policy (r_policy),
        .i_req    (in_ch.data),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_rsp    (out_ch.data)
    );

endmodule

/* rtl/drs_checker.sv */
//------------------------------------------------------------------------------
// drs_checker
// Port-level checks of the disk request scheduler.
//------------------------------------------------------------------------------
module drs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input drs_pkg::t_rsp out_data
);
    // one request in flight: no accept while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("accept while result pending");
    // a result without grant carries zero timing
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.granted |-> out_data.finish_time == '0)
        else $error("ungranted result has time");
    // finish never precedes start
    a_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.granted |-> out_data.finish_time >= out_data.start_time)
        else $error("finish before start");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
endmodule

bind disk_request_scheduler_unit drs_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
